// File: hdl/wsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform sample generator package
// Shared types for the top level and the arithmetic sequencer: waveform
// modes, register indexes, sequencer states and the request and status
// bundles.
// ----------------------------------------------------------------------------
package wsg_pkg;

  // Field widths that the interface fixes
  localparam int StepW   = 8;   // wide enough for the largest period length
  localparam int AmpW    = 7;
  localparam int SampleW = 12;

  // Register indexes of the configuration port
  localparam logic [1:0] CFG_WAVE_MODE = 2'd0;
  localparam logic [1:0] CFG_AMPLITUDE = 2'd1;
  localparam logic [1:0] CFG_RELOAD    = 2'd2;

  // Waveform selection codes
  typedef enum logic [1:0] {
    MODE_SINE   = 2'd0,
    MODE_SQUARE = 2'd1,
    MODE_SAW    = 2'd2,
    MODE_OFF    = 2'd3
  } wave_mode_t;

  // Sequencer states of the shared multiplier
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_FIX,
    ST_DONE
  } calc_state_t;

  // One sample request from the timebase logic
  typedef struct packed {
    wave_mode_t          mode;
    logic [AmpW-1:0]     amp;
    logic [StepW-1:0]    step;
    logic                last;
  } wsg_req_t;

  // Status returned by the sequencer
  typedef struct packed {
    logic                idle;
    logic                done;
    logic [SampleW-1:0]  sample;
    logic                last;
  } wsg_status_t;

endpackage

// File: hdl/waveform_sample_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform sample generator
// Counts timebase ticks and, every reload+1 ticks, emits one DAC sample of
// a sine, square or sawtooth wave from a stepped phase counter.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per timebase tick; in_tdata[0] = 1 counts a tick,
//           0 is accepted and ignored.
//   out_* : one transaction per sample; out_tdata[11:0] is the DAC code and
//           out_tlast marks the last step of a waveform period.
//   cfg_* : register writes (0 wave mode, 1 amplitude, 2 tick reload), always
//           accepted; the user must write only while no sample is in flight (the block does not enforce this).
//   A tick that does not produce a sample does not hold off input. A tick that
//   produces one keeps in_tready low while the shared multiplier sequence
//   runs through MUL1 (plus MUL2 for sine, MUL2 to MUL4 for sawtooth), FIX
//   and DONE, until the sample enters the output register.
//   If the receiver stalls, one sample waits in the output register and a
//   second waits in the sequencer; input is held off until space frees up.
//   Reset clears the counters and loads mode off, amplitude 0, reload 9999.
//   The sine table is constant, so no initialization pass is needed.
// ----------------------------------------------------------------------------
module waveform_sample_generator
  import wsg_pkg::*;
#(
  parameter int SAMPLES_PER_PERIOD = 100
) (
  input  logic        clk,
  input  logic        rst_n,
  // Tick input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [0] tick, [7:1] zero
  // Sample output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [11:0] sample, [15:12] zero
  output logic        out_tlast,   // period_end
  // Register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int PhaseW = $clog2(SAMPLES_PER_PERIOD);
  localparam logic [PhaseW-1:0] LastPhase = PhaseW'(SAMPLES_PER_PERIOD - 1);

  wave_mode_t         mode_r;
  logic [AmpW-1:0]    amp_r;
  logic [15:0]        reload_r;
  logic [15:0]        tick_count_r, tick_count_nxt;
  logic [PhaseW-1:0]  phase_r, phase_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SampleW-1:0] out_sample_r;
  logic               out_last_r;

  logic               in_accept;
  logic               tick_hit;
  logic               fire;
  logic               start;
  logic               load;
  wsg_req_t           req;
  wsg_status_t        calc_status;

  assign cfg_ready = 1'b1;
  assign in_tready = calc_status.idle;
  assign in_accept = in_tvalid && in_tready;
  assign tick_hit  = in_accept && in_tdata[0];
  assign fire      = tick_hit && (tick_count_r >= reload_r);
  assign start     = fire && (mode_r != MODE_OFF);

  // Sample request for the current phase step
  assign req.mode = mode_r;
  assign req.amp  = amp_r;
  assign req.step = StepW'(phase_r);
  assign req.last = (phase_r == LastPhase);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_OFF;
      amp_r    <= '0;
      reload_r <= 16'd9999;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WAVE_MODE: mode_r   <= wave_mode_t'(cfg_data[1:0]);
        CFG_AMPLITUDE: amp_r    <= cfg_data[AmpW-1:0];
        CFG_RELOAD:    reload_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Tick counter and phase step
  always_comb begin
    tick_count_nxt = tick_count_r;
    phase_nxt      = phase_r;
    if (tick_hit) begin
      if (tick_count_r < reload_r) begin
        tick_count_nxt = tick_count_r + 16'd1;
      end else begin
        tick_count_nxt = '0;
        phase_nxt      = (phase_r == LastPhase) ? '0 : phase_r + PhaseW'(1);
      end
    end
  end

  // Output register; it takes the sequencer result when free or draining
  assign load = calc_status.done && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
      phase_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      tick_count_r <= tick_count_nxt;
      phase_r      <= phase_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_sample_r <= calc_status.sample;
      out_last_r   <= calc_status.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_sample_r};
  assign out_tlast  = out_last_r;

  // Shared multiplier sequencer
  wsg_calc #(
    .SAMPLES_PER_PERIOD(SAMPLES_PER_PERIOD)
  ) u_calc (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .req    (req),
    .ack    (load),
    .status (calc_status)
  );

  // The phase step never leaves the period.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= LastPhase)
    else $error("waveform_sample_generator: phase out of range");

  // A sample-producing tick in an active mode holds off further input.
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_tready)
    else $error("waveform_sample_generator: sample tick did not start work");

endmodule

// File: hdl/wsg_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform sample arithmetic
// Computes one saturated 12-bit sample with a single shared multiplier that
// a small sequencer steps through one to four products, then a fix-up step.
// ----------------------------------------------------------------------------
module wsg_calc
  import wsg_pkg::*;
#(
  parameter int SAMPLES_PER_PERIOD = 100
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  wsg_req_t    req,
  input  logic        ack,
  output wsg_status_t status
);

  localparam int PhaseW     = $clog2(SAMPLES_PER_PERIOD);
  localparam int HalfPoint  = SAMPLES_PER_PERIOD / 2;
  localparam int SawDiv     = SAMPLES_PER_PERIOD - 1;
  localparam int RecipShift = 24;
  localparam int SawRecip   = (1 << RecipShift) / SawDiv;
  localparam int MulAW      = 22;
  localparam int MulBW      = 24;
  localparam int ProdW      = MulAW + MulBW;

  localparam logic [63:0]      HalfPiQ30  = 64'd1686629713;
  localparam logic [MulBW-1:0] GainSine   = 24'd3195660;
  localparam logic [MulBW-1:0] GainSquare = 24'd6212267;
  localparam logic [MulBW-1:0] GainSaw    = 24'd6642820;
  localparam logic [MulBW-1:0] SawRecipB  = MulBW'(SawRecip);
  localparam logic [MulBW-1:0] SawDivB    = MulBW'(SawDiv);
  localparam logic [MulAW-1:0] SawDivA    = MulAW'(SawDiv);
  localparam logic [MulAW-1:0] SampleMax  = MulAW'(4095);

  // Q14 sine of one table step, from a truncating Q30 Taylor series
  function automatic logic [14:0] sine_entry(input int unsigned idx);
    logic [63:0]  x;
    logic [63:0]  theta;
    logic [63:0]  th2;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [63:0]  q;
    logic [14:0]  mag;
    int unsigned  k4;
    int unsigned  quad;
    int unsigned  r;
    k4   = 4 * idx;
    quad = k4 / SAMPLES_PER_PERIOD;
    r    = k4 % SAMPLES_PER_PERIOD;
    if (quad % 2 == 1) begin
      r = SAMPLES_PER_PERIOD - r;
    end
    x     = (64'(r) << 30) / SAMPLES_PER_PERIOD;
    theta = (x * HalfPiQ30) >> 30;
    th2   = (theta * theta) >> 30;
    term  = theta;
    sum   = theta;
    term  = ((term * th2) >> 30) / 6;
    sum   = (sum >= term) ? sum - term : 64'd0;
    term  = ((term * th2) >> 30) / 20;
    sum   = sum + term;
    term  = ((term * th2) >> 30) / 42;
    sum   = (sum >= term) ? sum - term : 64'd0;
    term  = ((term * th2) >> 30) / 72;
    sum   = sum + term;
    term  = ((term * th2) >> 30) / 110;
    sum   = (sum >= term) ? sum - term : 64'd0;
    term  = ((term * th2) >> 30) / 156;
    sum   = sum + term;
    term  = ((term * th2) >> 30) / 210;
    sum   = (sum >= term) ? sum - term : 64'd0;
    q     = (sum + 64'd32768) >> 16;
    if (q > 64'd16383) begin
      q = 64'd16383;
    end
    mag = q[14:0];
    return (quad >= 2) ? (~mag + 15'd1) : mag;
  endfunction

  // Constant sine table, one entry per phase step
  logic signed [14:0] sine_rom [SAMPLES_PER_PERIOD];

  for (genvar g = 0; g < SAMPLES_PER_PERIOD; g++) begin : g_rom
    localparam logic [14:0] RomEntry = sine_entry(g);
    assign sine_rom[g] = RomEntry;
  end

  calc_state_t        state_r, state_nxt;
  wsg_req_t           req_r;
  logic [14:0]        off_r;
  logic [ProdW-1:0]   prod_r;
  logic [MulAW-1:0]   q1_r;
  logic [MulAW-1:0]   qe_r;
  logic [SampleW-1:0] sample_r;

  logic signed [14:0] rom_rd;
  logic [15:0]        off_sum;
  logic [MulAW-1:0]   mul_a;
  logic [MulBW-1:0]   mul_b;
  logic [ProdW-1:0]   product;
  logic [MulAW-1:0]   rem;
  logic [MulAW-1:0]   val;

  // Table lookup and sine offset, captured when a request starts
  assign rom_rd  = sine_rom[req.step[PhaseW-1:0]];
  assign off_sum = 16'd16384 + 16'(rom_rd);

  // Shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MUL1: begin
        case (req_r.mode)
          MODE_SINE: begin
            mul_a = MulAW'(off_r);
            mul_b = MulBW'(req_r.amp);
          end
          MODE_SQUARE: begin
            mul_a = MulAW'(req_r.amp);
            mul_b = GainSquare;
          end
          default: begin
            mul_a = MulAW'(req_r.step);
            mul_b = MulBW'(req_r.amp);
          end
        endcase
      end
      ST_MUL2: begin
        mul_a = prod_r[MulAW-1:0];
        mul_b = (req_r.mode == MODE_SINE) ? GainSine : GainSaw;
      end
      ST_MUL3: begin
        mul_a = prod_r[37:16];
        mul_b = SawRecipB;
      end
      ST_MUL4: begin
        mul_a = prod_r[RecipShift+MulAW-1:RecipShift];
        mul_b = SawDivB;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = ProdW'(mul_a) * ProdW'(mul_b);

  // Final scaling and quotient correction; saturation is applied in ST_FIX
  always_comb begin
    rem = q1_r - prod_r[MulAW-1:0];
    case (req_r.mode)
      MODE_SINE:   val = MulAW'(prod_r[ProdW-1:30]);
      MODE_SQUARE: val = (req_r.step < StepW'(HalfPoint)) ? '0 : prod_r[37:16];
      MODE_SAW:    val = (rem >= SawDivA) ? qe_r + MulAW'(1) : qe_r;
      default:     val = '0;
    endcase
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = (req_r.mode == MODE_SQUARE) ? ST_FIX : ST_MUL2;
      ST_MUL2: state_nxt = (req_r.mode == MODE_SINE) ? ST_FIX : ST_MUL3;
      ST_MUL3: state_nxt = ST_MUL4;
      ST_MUL4: state_nxt = ST_FIX;
      ST_FIX:  state_nxt = ST_DONE;
      ST_DONE: if (ack) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      req_r <= req;
      off_r <= off_sum[14:0];
    end
    prod_r <= product;
    if (state_r == ST_MUL3) begin
      q1_r <= prod_r[37:16];
    end
    if (state_r == ST_MUL4) begin
      qe_r <= prod_r[RecipShift+MulAW-1:RecipShift];
    end
    if (state_r == ST_FIX) begin
      sample_r <= (val > SampleMax) ? SampleW'(4095) : val[SampleW-1:0];
    end
  end

  assign status.idle   = (state_r == ST_IDLE);
  assign status.done   = (state_r == ST_DONE);
  assign status.sample = sample_r;
  assign status.last   = req_r.last;

  // A request only arrives while the sequencer is free.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == ST_IDLE)
    else $error("wsg_calc: request while busy");

  // A finished sample waits unchanged until it is taken.
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !ack) |=> (state_r == ST_DONE && $stable(sample_r)))
    else $error("wsg_calc: pending sample lost or changed");

endmodule
